>>> hw/rtl/bhist_pkg.sv
`default_nettype none

package bhist_pkg;

    localparam int NUM_BINS   = 256;
    localparam int BIN_W      = 8;
    localparam int FRAC_W     = 17;
    localparam int FRAC_BITS  = 16;
    localparam int LEVEL_W    = 32;
    localparam int STEP_W     = 31;
    localparam int STATUS_W   = 3;
    localparam int CMD_W      = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int MUL_CNT_W  = 4;
    localparam int LVL_PROD_W = BIN_W + STEP_W;
    localparam int LVL_SUM_W  = LVL_PROD_W + 2;

    localparam logic [BIN_W-1:0]     TOP_BIN  = 8'd255;
    localparam logic [MUL_CNT_W-1:0] MUL_LAST = 4'd15;

    localparam logic signed [LVL_SUM_W-1:0] LVL_SUM_MAX = 41'sd2147483647;
    localparam logic signed [LVL_SUM_W-1:0] LVL_SUM_MIN = -41'sd2147483648;
    localparam logic signed [LEVEL_W-1:0]   LEVEL_MAX   = 32'sh7FFF_FFFF;
    localparam logic signed [LEVEL_W-1:0]   LEVEL_MIN   = 32'sh8000_0000;

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_SAMPLE = 2'd1,
        CMD_QUERY  = 2'd2
    } t_command;

    typedef enum logic [STATUS_W-1:0] {
        ST_FOUND       = 3'd0,
        ST_EMPTY       = 3'd1,
        ST_FRAC_ZERO   = 3'd2,
        ST_FRAC_ONE    = 3'd3,
        ST_NOT_REACHED = 3'd4
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LEVEL_BASE  = 2'd0,
        CFG_LEVEL_STEP  = 2'd1,
        CFG_MAP_MINIMUM = 2'd2,
        CFG_MAP_MAXIMUM = 2'd3
    } t_cfg_index;

    typedef struct packed {
        logic    item_load;
        logic    clear_all;
        logic    smp_read;
        logic    smp_write;
        logic    mul_init;
        logic    mul_step;
        logic    walk_init;
        logic    walk_step;
        logic    lvl_mul;
        logic    lvl_add;
        logic    out_load;
        t_status out_status;
    } t_dp_cmd;

    typedef struct packed {
        logic total_zero;
        logic frac_zero;
        logic frac_ge_one;
        logic hit;
        logic walk_end;
        logic out_free;
    } t_dp_sts;

endpackage

`default_nettype wire

>>> hw/rtl/bhist_ctrl.sv
`default_nettype none

module bhist_ctrl (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_in_valid,
    output logic                         o_in_ready,
    input  wire [bhist_pkg::CMD_W-1:0]   i_command,
    input  wire bhist_pkg::t_dp_sts      i_sts,
    output bhist_pkg::t_dp_cmd           o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLEAR,
        S_SMP_RD,
        S_SMP_WR,
        S_QCHK,
        S_MUL,
        S_TGT,
        S_WALK,
        S_LVL_MUL,
        S_LVL_ADD,
        S_OUT
    } t_state;

    t_state                          r_state;
    logic [bhist_pkg::MUL_CNT_W-1:0] r_mul_cnt;
    bhist_pkg::t_status              r_status;

    assign o_in_ready = i_rst_n && (r_state == S_IDLE);

    always_comb begin
        o_cmd            = '0;
        o_cmd.out_status = r_status;
        unique case (r_state)
            S_IDLE:    o_cmd.item_load = i_in_valid;
            S_CLEAR:   o_cmd.clear_all = 1'b1;
            S_SMP_RD:  o_cmd.smp_read  = 1'b1;
            S_SMP_WR:  o_cmd.smp_write = 1'b1;
            S_QCHK:    o_cmd.mul_init  = !(i_sts.total_zero || i_sts.frac_zero ||
                                           i_sts.frac_ge_one);
            S_MUL:     o_cmd.mul_step  = 1'b1;
            S_TGT:     o_cmd.walk_init = 1'b1;
            S_WALK:    o_cmd.walk_step = 1'b1;
            S_LVL_MUL: o_cmd.lvl_mul   = 1'b1;
            S_LVL_ADD: o_cmd.lvl_add   = 1'b1;
            S_OUT:     o_cmd.out_load  = i_sts.out_free;
            default:   ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_mul_cnt <= '0;
            r_status  <= bhist_pkg::ST_FOUND;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        unique case (bhist_pkg::t_command'(i_command))
                            bhist_pkg::CMD_CLEAR:  r_state <= S_CLEAR;
                            bhist_pkg::CMD_SAMPLE: r_state <= S_SMP_RD;
                            bhist_pkg::CMD_QUERY:  r_state <= S_QCHK;
                            default:               r_state <= S_IDLE;
                        endcase
                    end
                end
                S_CLEAR:  r_state <= S_IDLE;
                S_SMP_RD: r_state <= S_SMP_WR;
                S_SMP_WR: r_state <= S_IDLE;
                S_QCHK: begin
                    priority if (i_sts.total_zero) begin
                        r_status <= bhist_pkg::ST_EMPTY;
                        r_state  <= S_OUT;
                    end else if (i_sts.frac_zero) begin
                        r_status <= bhist_pkg::ST_FRAC_ZERO;
                        r_state  <= S_OUT;
                    end else if (i_sts.frac_ge_one) begin
                        r_status <= bhist_pkg::ST_FRAC_ONE;
                        r_state  <= S_OUT;
                    end else begin
                        r_mul_cnt <= '0;
                        r_state   <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_mul_cnt <= r_mul_cnt + 1'b1;
                    if (r_mul_cnt == bhist_pkg::MUL_LAST) begin
                        r_state <= S_TGT;
                    end
                end
                S_TGT: r_state <= S_WALK;
                S_WALK: begin
                    priority if (i_sts.hit) begin
                        r_state <= S_LVL_MUL;
                    end else if (i_sts.walk_end) begin
                        r_status <= bhist_pkg::ST_NOT_REACHED;
                        r_state  <= S_OUT;
                    end else begin
                        r_state <= S_WALK;
                    end
                end
                S_LVL_MUL: r_state <= S_LVL_ADD;
                S_LVL_ADD: begin
                    r_status <= bhist_pkg::ST_FOUND;
                    r_state  <= S_OUT;
                end
                S_OUT: begin
                    if (i_sts.out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/bhist_dp.sv
`default_nettype none

module bhist_dp #(
    parameter int COUNT_WIDTH = 32
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire bhist_pkg::t_dp_cmd               i_cmd,
    output bhist_pkg::t_dp_sts                    o_sts,
    input  wire [bhist_pkg::BIN_W-1:0]            i_sample_byte,
    input  wire [bhist_pkg::FRAC_W-1:0]           i_fraction,
    input  wire                                   i_cfg_valid,
    input  wire [bhist_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  wire [bhist_pkg::LEVEL_W-1:0]          i_cfg_data,
    output logic                                  o_out_valid,
    input  wire                                   i_out_ready,
    output logic signed [bhist_pkg::LEVEL_W-1:0]  o_level,
    output logic [bhist_pkg::BIN_W-1:0]           o_bin_index,
    output logic [bhist_pkg::STATUS_W-1:0]        o_status
);

    localparam int PROD_W = COUNT_WIDTH + bhist_pkg::FRAC_BITS;
    localparam int ACC_W  = COUNT_WIDTH + 1;
    localparam logic [PROD_W-1:0] ROUND_UP = PROD_W'((1 << bhist_pkg::FRAC_BITS) - 1);

    // item and configuration
    logic [bhist_pkg::BIN_W-1:0]          r_byte;
    logic [bhist_pkg::FRAC_W-1:0]         r_frac;
    logic signed [bhist_pkg::LEVEL_W-1:0] r_level_base;
    logic [bhist_pkg::STEP_W-1:0]         r_level_step;
    logic signed [bhist_pkg::LEVEL_W-1:0] r_map_min;
    logic signed [bhist_pkg::LEVEL_W-1:0] r_map_max;

    // histogram store
    logic [COUNT_WIDTH-1:0]         r_mem [bhist_pkg::NUM_BINS];
    logic [bhist_pkg::NUM_BINS-1:0] r_valid;
    logic [COUNT_WIDTH-1:0]         r_total;
    logic [COUNT_WIDTH-1:0]         r_rd_data;
    logic                           r_rd_ok;
    logic [bhist_pkg::BIN_W-1:0]    r_rd_bin;

    // target multiply
    logic [PROD_W-1:0]               r_mcand;
    logic [bhist_pkg::FRAC_BITS-1:0] r_mplier;
    logic [PROD_W-1:0]               r_prod;
    logic [COUNT_WIDTH-1:0]          r_target;

    // walk
    logic [bhist_pkg::BIN_W-1:0] r_waddr;
    logic                        r_issue_done;
    logic                        r_walk_vld;
    logic [ACC_W-1:0]            r_acc;
    logic                        r_hit;
    logic                        r_walk_end;
    logic [bhist_pkg::BIN_W-1:0] r_hit_bin;

    // level and result
    logic [bhist_pkg::LVL_PROD_W-1:0]     r_lprod;
    logic signed [bhist_pkg::LEVEL_W-1:0] r_level;
    logic                                 r_out_vld;
    logic signed [bhist_pkg::LEVEL_W-1:0] r_out_level;
    logic [bhist_pkg::BIN_W-1:0]          r_out_bin;
    logic [bhist_pkg::STATUS_W-1:0]       r_out_status;

    logic                                   w_rd_en;
    logic [bhist_pkg::BIN_W-1:0]            w_rd_addr;
    logic [COUNT_WIDTH-1:0]                 w_count;
    logic [COUNT_WIDTH-1:0]                 w_count_inc;
    logic [COUNT_WIDTH-1:0]                 w_total_inc;
    logic [ACC_W-1:0]                       w_acc_sum;
    logic                                   w_hit_now;
    logic                                   w_walk_proc;
    logic [PROD_W-1:0]                      w_round;
    logic signed [bhist_pkg::LVL_SUM_W-1:0] w_lsum;

    assign w_rd_en   = i_cmd.smp_read || (i_cmd.walk_step && !r_issue_done);
    assign w_rd_addr = i_cmd.smp_read ? r_byte : r_waddr;

    // entries never written since the last clear read as zero
    assign w_count     = r_rd_ok ? r_rd_data : '0;
    assign w_count_inc = (&w_count) ? w_count : w_count + 1'b1;
    assign w_total_inc = (&r_total) ? r_total : r_total + 1'b1;

    assign w_acc_sum   = r_acc + ACC_W'(w_count);
    assign w_hit_now   = (w_acc_sum >= {1'b0, r_target});
    assign w_walk_proc = r_walk_vld && !r_hit && !r_walk_end;

    assign w_round = r_prod + ROUND_UP;
    assign w_lsum  = $signed({2'b00, r_lprod}) + bhist_pkg::LVL_SUM_W'(r_level_base);

    always_ff @(posedge i_clk) begin
        if (i_cmd.item_load) begin
            r_byte <= i_sample_byte;
            r_frac <= i_fraction;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level_base <= '0;
            r_level_step <= '0;
            r_map_min    <= '0;
            r_map_max    <= '0;
        end else if (i_cfg_valid) begin
            unique case (bhist_pkg::t_cfg_index'(i_cfg_index))
                bhist_pkg::CFG_LEVEL_BASE:  r_level_base <= i_cfg_data;
                bhist_pkg::CFG_LEVEL_STEP:  r_level_step <= i_cfg_data[bhist_pkg::STEP_W-1:0];
                bhist_pkg::CFG_MAP_MINIMUM: r_map_min    <= i_cfg_data;
                bhist_pkg::CFG_MAP_MAXIMUM: r_map_max    <= i_cfg_data;
            endcase
        end
    end

    // single port store, registered read
    always_ff @(posedge i_clk) begin
        if (w_rd_en) begin
            r_rd_data <= r_mem[w_rd_addr];
            r_rd_ok   <= r_valid[w_rd_addr];
            r_rd_bin  <= w_rd_addr;
        end
        if (i_cmd.smp_write) begin
            r_mem[r_byte] <= w_count_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= '0;
            r_total      <= '0;
            r_issue_done <= 1'b0;
            r_walk_vld   <= 1'b0;
            r_hit        <= 1'b0;
            r_walk_end   <= 1'b0;
            r_out_vld    <= 1'b0;
        end else begin
            if (i_cmd.clear_all) begin
                r_valid <= '0;
                r_total <= '0;
            end
            if (i_cmd.smp_write) begin
                r_valid[r_byte] <= 1'b1;
                r_total         <= w_total_inc;
            end
            r_walk_vld <= i_cmd.walk_step && !r_issue_done;
            if (i_cmd.walk_init) begin
                r_issue_done <= 1'b0;
                r_hit        <= 1'b0;
                r_walk_end   <= 1'b0;
            end else begin
                if (i_cmd.walk_step && !r_issue_done && (r_waddr == '0)) begin
                    r_issue_done <= 1'b1;
                end
                if (w_walk_proc) begin
                    // bin zero is the last one read
                    priority if (w_hit_now) begin
                        r_hit <= 1'b1;
                    end else begin
                        r_walk_end <= (r_rd_bin == '0);
                    end
                end
            end
            if (i_cmd.out_load) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        // shift-add: one fraction bit per cycle
        if (i_cmd.mul_init) begin
            r_mcand  <= PROD_W'(r_total);
            r_mplier <= r_frac[bhist_pkg::FRAC_BITS-1:0];
            r_prod   <= '0;
        end else if (i_cmd.mul_step) begin
            if (r_mplier[0]) begin
                r_prod <= r_prod + r_mcand;
            end
            r_mcand  <= r_mcand << 1;
            r_mplier <= r_mplier >> 1;
        end

        if (i_cmd.walk_init) begin
            r_target <= w_round[PROD_W-1:bhist_pkg::FRAC_BITS];
            r_waddr  <= bhist_pkg::TOP_BIN;
            r_acc    <= '0;
        end else begin
            if (i_cmd.walk_step && !r_issue_done) begin
                r_waddr <= r_waddr - 1'b1;
            end
            if (w_walk_proc) begin
                r_acc <= w_acc_sum;
                if (w_hit_now) begin
                    r_hit_bin <= r_rd_bin;
                end
            end
        end

        if (i_cmd.lvl_mul) begin
            r_lprod <= bhist_pkg::LVL_PROD_W'(r_hit_bin) *
                       bhist_pkg::LVL_PROD_W'(r_level_step);
        end
        if (i_cmd.lvl_add) begin
            priority if (w_lsum > bhist_pkg::LVL_SUM_MAX) begin
                r_level <= bhist_pkg::LEVEL_MAX;
            end else if (w_lsum < bhist_pkg::LVL_SUM_MIN) begin
                r_level <= bhist_pkg::LEVEL_MIN;
            end else begin
                r_level <= w_lsum[bhist_pkg::LEVEL_W-1:0];
            end
        end

        if (i_cmd.out_load) begin
            r_out_status <= i_cmd.out_status;
            unique case (i_cmd.out_status)
                bhist_pkg::ST_FOUND: begin
                    r_out_level <= r_level;
                    r_out_bin   <= r_hit_bin;
                end
                bhist_pkg::ST_FRAC_ZERO: begin
                    r_out_level <= r_map_max;
                    r_out_bin   <= '0;
                end
                bhist_pkg::ST_FRAC_ONE, bhist_pkg::ST_NOT_REACHED: begin
                    r_out_level <= r_map_min;
                    r_out_bin   <= '0;
                end
                default: begin
                    r_out_level <= '0;
                    r_out_bin   <= '0;
                end
            endcase
        end
    end

    assign o_sts.total_zero  = (r_total == '0);
    assign o_sts.frac_zero   = (r_frac == '0);
    assign o_sts.frac_ge_one = r_frac[bhist_pkg::FRAC_W-1];
    assign o_sts.hit         = r_hit;
    assign o_sts.walk_end    = r_walk_end;
    assign o_sts.out_free    = !r_out_vld || i_out_ready;

    assign o_out_valid = r_out_vld;
    assign o_level     = r_out_level;
    assign o_bin_index = r_out_bin;
    assign o_status    = r_out_status;

endmodule

`default_nettype wire

>>> hw/rtl/byte_histogram_top_fraction_level_core.sv
// Clear and sample pass one item at a time through the controller. Query: straight to
//   the result when empty or fraction is zero or at least one; otherwise a shift-add
//   multiply forms the target, then the bin walk runs one bin per cycle (up to 256 bins),
//   then level multiply and add. The single store port and 16-step multiply set the query time.
// Reset (i_rst_n low, synchronous): histogram empty, total zero, configuration registers
//   zero, no result pending. No clearing pass: per-bin valid flags clear at once.
`default_nettype none

module byte_histogram_top_fraction_level_core #(
    parameter int COUNT_WIDTH = 32
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    // item channel
    input  wire                                   i_in_valid,
    output logic                                  o_in_ready,
    input  wire [bhist_pkg::CMD_W-1:0]            i_command,
    input  wire [bhist_pkg::BIN_W-1:0]            i_sample_byte,
    input  wire [bhist_pkg::FRAC_W-1:0]           i_fraction,
    // result channel
    output logic                                  o_out_valid,
    input  wire                                   i_out_ready,
    output logic signed [bhist_pkg::LEVEL_W-1:0]  o_level,
    output logic [bhist_pkg::BIN_W-1:0]           o_bin_index,
    output logic [bhist_pkg::STATUS_W-1:0]        o_status,
    // register write channel
    input  wire                                   i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire [bhist_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  wire [bhist_pkg::LEVEL_W-1:0]          i_cfg_data
);

    // Controller sequences each command; datapath holds the histogram,
    // the target multiplier, the running-sum walk and the result register.
    bhist_pkg::t_dp_cmd w_cmd;
    bhist_pkg::t_dp_sts w_sts;

    // register writes complete in one transfer, none taken in reset
    assign o_cfg_ready = i_rst_n;

    bhist_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_command  (i_command),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // The result register parts the two sides: a new item is taken while a
    // result still waits, and a finished query only stalls for a free slot.
    bhist_dp #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_sample_byte (i_sample_byte),
        .i_fraction    (i_fraction),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_level       (o_level),
        .o_bin_index   (o_bin_index),
        .o_status      (o_status)
    );

    // the result register is only loaded when it is free
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> w_sts.out_free)
        else $error("result loaded over a pending transfer");

    // a walk ends either with a hit or with all bins spent, never both
    a_walk_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sts.hit |-> !w_sts.walk_end)
        else $error("walk flagged hit and end together");

    // only a found threshold reports a bin
    a_bin_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status != bhist_pkg::ST_FOUND)) |-> (o_bin_index == '0))
        else $error("nonzero bin without found status");

    // empty histogram reports level zero
    a_empty_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == bhist_pkg::ST_EMPTY)) |-> (o_level == '0))
        else $error("empty status with nonzero level");

endmodule

`default_nettype wire

>>> tb/byte_histogram_top_fraction_level_core_tb.sv
module byte_histogram_top_fraction_level_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Command code 3 is not decoded by the block; it must be dropped silently.
    localparam logic [bhist_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

    localparam logic [bhist_pkg::FRAC_W-1:0] FRAC_ONE = 17'h10000;

    // Items per random phase, and the number of phases (register settings).
    localparam int PHASE_ITEMS = 276;
    localparam int NUM_PHASES  = 5;

    // A query walks up to 256 bins after a 16-step multiply.
    localparam int SETTLE_CYCLES = 320;

    // Long receiver hold-off, so the core backs up and drops o_in_ready.
    localparam int HOLD_CYCLES = 2000;

    // Watchdog: the slowest legal run is well under 4 ms.
    localparam int WATCHDOG_NS = 12_000_000;

    // Receiver stall patterns
    localparam int SINK_ALWAYS       = 0;
    localparam int SINK_COIN         = 1;
    localparam int SINK_EVERY_FOURTH = 2;
    localparam int SINK_SPARSE       = 3;

    typedef struct {
        logic signed [bhist_pkg::LEVEL_W-1:0] level;
        logic [bhist_pkg::BIN_W-1:0]          bin;
        bhist_pkg::t_status                   status;
    } t_threshold_result;

    // Shadow of the histogram and the registers. Every accepted item goes
    // through take_item(); queries push the threshold they must return.
    class level_scoreboard;
        logic [31:0]                          bin_count [bhist_pkg::NUM_BINS];
        logic [31:0]                          sample_total;
        logic signed [bhist_pkg::LEVEL_W-1:0] level_base;
        logic [bhist_pkg::STEP_W-1:0]         level_step;
        logic signed [bhist_pkg::LEVEL_W-1:0] map_minimum;
        logic signed [bhist_pkg::LEVEL_W-1:0] map_maximum;
        t_threshold_result                    pending [$];
        int unsigned                          mismatches;

        function new();
            foreach (bin_count[i]) bin_count[i] = '0;
            sample_total = '0;
            level_base   = '0;
            level_step   = '0;
            map_minimum  = '0;
            map_maximum  = '0;
            mismatches   = 0;
        endfunction

        function void set_register(bhist_pkg::t_cfg_index idx,
                                   logic [bhist_pkg::LEVEL_W-1:0] data);
            case (idx)
                bhist_pkg::CFG_LEVEL_BASE:  level_base  = data;
                bhist_pkg::CFG_LEVEL_STEP:  level_step  = data[bhist_pkg::STEP_W-1:0];
                bhist_pkg::CFG_MAP_MINIMUM: map_minimum = data;
                bhist_pkg::CFG_MAP_MAXIMUM: map_maximum = data;
                default: ;
            endcase
        endfunction

        function t_threshold_result predict_query(logic [bhist_pkg::FRAC_W-1:0] fr);
            t_threshold_result r;
            logic [63:0]       target;
            logic [63:0]       running;
            longint            lvl;
            int                b;
            bit                found;
            r.level = '0;
            r.bin   = '0;
            if (sample_total == 0) begin
                r.status = bhist_pkg::ST_EMPTY;
            end else if (fr == 0) begin
                r.status = bhist_pkg::ST_FRAC_ZERO;
                r.level  = map_maximum;
            end else if (fr >= FRAC_ONE) begin
                r.status = bhist_pkg::ST_FRAC_ONE;
                r.level  = map_minimum;
            end else begin
                // ceil(total * f / 2^16), split so nothing overflows
                target = 64'(sample_total[31:16]) * 64'(fr)
                       + ((64'(sample_total[15:0]) * 64'(fr) + 64'hFFFF) >> 16);
                r.status = bhist_pkg::ST_NOT_REACHED;
                r.level  = map_minimum;
                running  = '0;
                found    = 1'b0;
                // 32-bit counts into a 64-bit sum: no overflow possible here
                for (b = bhist_pkg::NUM_BINS - 1; b >= 0 && !found; b--) begin
                    running = running + 64'(bin_count[b]);
                    if (running >= target) begin
                        found = 1'b1;
                        lvl = longint'(b) * longint'({1'b0, level_step})
                            + longint'(level_base);
                        if (lvl > longint'(bhist_pkg::LEVEL_MAX))
                            lvl = longint'(bhist_pkg::LEVEL_MAX);
                        if (lvl < longint'(bhist_pkg::LEVEL_MIN))
                            lvl = longint'(bhist_pkg::LEVEL_MIN);
                        r.level  = lvl[bhist_pkg::LEVEL_W-1:0];
                        r.bin    = b[bhist_pkg::BIN_W-1:0];
                        r.status = bhist_pkg::ST_FOUND;
                    end
                end
            end
            return r;
        endfunction

        function void take_item(logic [bhist_pkg::CMD_W-1:0] cmd,
                                logic [bhist_pkg::BIN_W-1:0] sb,
                                logic [bhist_pkg::FRAC_W-1:0] fr);
            case (cmd)
                bhist_pkg::CMD_CLEAR: begin
                    foreach (bin_count[i]) bin_count[i] = '0;
                    sample_total = '0;
                end
                bhist_pkg::CMD_SAMPLE: begin
                    // counts stick at all-ones
                    if (bin_count[sb] != '1) bin_count[sb] = bin_count[sb] + 32'd1;
                    if (sample_total != '1) sample_total = sample_total + 32'd1;
                end
                bhist_pkg::CMD_QUERY: pending.push_back(predict_query(fr));
                default: ;
            endcase
        endfunction

        function void check_result(logic signed [bhist_pkg::LEVEL_W-1:0] lvl,
                                   logic [bhist_pkg::BIN_W-1:0] bin,
                                   logic [bhist_pkg::STATUS_W-1:0] st);
            t_threshold_result want;
            if (pending.size() == 0) begin
                $error("result with no query outstanding: level %0d bin %0d status %0d",
                       lvl, bin, st);
                mismatches++;
            end else begin
                want = pending.pop_front();
                if (lvl !== want.level) begin
                    $error("level: expected %0d, got %0d", want.level, lvl);
                    mismatches++;
                end
                if (bin !== want.bin) begin
                    $error("bin_index: expected %0d, got %0d", want.bin, bin);
                    mismatches++;
                end
                if (st !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, st);
                    mismatches++;
                end
            end
        endfunction
    endclass

    // ------------------------------------------------------------------
    // Clock, reset and block inputs (all known from time zero)
    // ------------------------------------------------------------------
    logic                             i_clk = 1'b0;
    logic                             i_rst_n = 1'b0;
    logic                             i_in_valid = 1'b0;
    logic [bhist_pkg::CMD_W-1:0]      i_command = bhist_pkg::CMD_CLEAR;
    logic [bhist_pkg::BIN_W-1:0]      i_sample_byte = '0;
    logic [bhist_pkg::FRAC_W-1:0]     i_fraction = '0;
    logic                             i_out_ready = 1'b0;
    logic                             i_cfg_valid = 1'b0;
    logic [bhist_pkg::CFG_IDX_W-1:0]  i_cfg_index = bhist_pkg::CFG_LEVEL_BASE;
    logic [bhist_pkg::LEVEL_W-1:0]    i_cfg_data = '0;

    logic                                 o_in_ready;
    logic                                 o_out_valid;
    logic signed [bhist_pkg::LEVEL_W-1:0] o_level;
    logic [bhist_pkg::BIN_W-1:0]          o_bin_index;
    logic [bhist_pkg::STATUS_W-1:0]       o_status;
    logic                                 o_cfg_ready;

    level_scoreboard board;

    // Handshake between stimulus and the result sink for the long hold-off.
    // Each flag has a single writer.
    bit hold_wanted = 1'b0;
    bit hold_done   = 1'b0;

    // Sender burst state
    int unsigned burst_left = 0;

    always #2 i_clk = ~i_clk;

    byte_histogram_top_fraction_level_core u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_command     (i_command),
        .i_sample_byte (i_sample_byte),
        .i_fraction    (i_fraction),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_level       (o_level),
        .o_bin_index   (o_bin_index),
        .o_status      (o_status),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // ------------------------------------------------------------------
    // Monitors. Inputs change only through NBAs at the edge, so the values
    // seen here are the ones the block sampled at this same edge.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && o_in_ready)
            board.take_item(i_command, i_sample_byte, i_fraction);
        if (i_rst_n && o_out_valid && i_out_ready)
            board.check_result(o_level, o_bin_index, o_status);
    end

    // ------------------------------------------------------------------
    // Result sink: switches between random stall patterns, and once does a long
    // hold-off on request while items keep coming.
    // ------------------------------------------------------------------
    initial begin : result_sink
        int unsigned mode;
        int unsigned mode_left;
        int unsigned hold_left;
        int unsigned tick;
        mode      = SINK_ALWAYS;
        mode_left = 0;
        hold_left = 0;
        tick      = 0;
        forever begin
            @(posedge i_clk);
            tick++;
            if (hold_wanted && !hold_done) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left != 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode      = $urandom_range(SINK_SPARSE, SINK_ALWAYS);
                    mode_left = $urandom_range(16, 200);
                end
                mode_left--;
                case (mode)
                    SINK_ALWAYS:       i_out_ready <= 1'b1;
                    SINK_COIN:         i_out_ready <= 1'($urandom_range(1, 0));
                    SINK_EVERY_FOURTH: i_out_ready <= (tick % 4 == 0);
                    default:           i_out_ready <= ($urandom_range(4, 0) == 0);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Item sender: bursts of random length, random gaps between them.
    // Valid stays high across back-to-back transfers in a burst.
    // ------------------------------------------------------------------
    task automatic send_item(logic [bhist_pkg::CMD_W-1:0] cmd,
                             logic [bhist_pkg::BIN_W-1:0] sb,
                             logic [bhist_pkg::FRAC_W-1:0] fr);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            // now and then a long burst with no idling at all
            burst_left = ($urandom_range(7, 0) == 0) ? 200 : $urandom_range(1, 30);
        end
        burst_left--;
        i_in_valid    <= 1'b1;
        i_command     <= cmd;
        i_sample_byte <= sb;
        i_fraction    <= fr;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic stop_items();
        i_in_valid <= 1'b0;
        burst_left = 0;
    endtask

    // Wait for every outstanding query, then let a trailing clear/sample
    // (which gives no result) finish before touching the registers.
    // The first edge lets the monitor note an item taken at the last edge.
    task automatic drain();
        @(posedge i_clk);
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(bhist_pkg::t_cfg_index idx,
                                  logic [bhist_pkg::LEVEL_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        board.set_register(idx, data);
    endtask

    task automatic load_registers(logic [bhist_pkg::LEVEL_W-1:0] base,
                                  logic [bhist_pkg::LEVEL_W-1:0] step,
                                  logic [bhist_pkg::LEVEL_W-1:0] minimum,
                                  logic [bhist_pkg::LEVEL_W-1:0] maximum);
        write_register(bhist_pkg::CFG_LEVEL_BASE, base);
        write_register(bhist_pkg::CFG_LEVEL_STEP, step);
        write_register(bhist_pkg::CFG_MAP_MINIMUM, minimum);
        write_register(bhist_pkg::CFG_MAP_MAXIMUM, maximum);
        i_cfg_valid <= 1'b0;
    endtask

    // One random item. Mostly samples so the histogram builds up between
    // the rare clears; queries hit the interesting fractions often.
    // Returns 0 for the ignored command code.
    task automatic random_item(int unsigned center, output bit counted);
        logic [bhist_pkg::CMD_W-1:0]  cmd;
        logic [bhist_pkg::BIN_W-1:0]  sb;
        logic [bhist_pkg::FRAC_W-1:0] fr;
        int unsigned                  pick;
        pick = $urandom_range(99, 0);
        if (pick < 2)       cmd = bhist_pkg::CMD_CLEAR;
        else if (pick < 4)  cmd = CMD_UNUSED;
        else if (pick < 82) cmd = bhist_pkg::CMD_SAMPLE;
        else                cmd = bhist_pkg::CMD_QUERY;

        // clustered bytes make the threshold land on varied bins
        if ($urandom_range(1, 0) == 0)
            sb = 8'($urandom_range(255, 0));
        else
            sb = 8'($urandom_range(center + 15, center));

        pick = $urandom_range(99, 0);
        if (pick < 5)       fr = '0;
        else if (pick < 8)  fr = FRAC_ONE;
        else if (pick < 13) fr = 17'($urandom_range(131071, 65537));
        else if (pick < 23) fr = 17'($urandom_range(255, 1));
        else if (pick < 33) fr = 17'($urandom_range(65535, 65280));
        else                fr = 17'($urandom_range(65535, 1));

        send_item(cmd, sb, fr);
        counted = (cmd != CMD_UNUSED);
    endtask

    // Register settings per phase: the two extremes first, then ordinary
    // Q16.16 steps and fully random values.
    task automatic apply_phase_registers(int phase);
        case (phase)
            0: load_registers(32'h8000_0000, 32'h0000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
            1: load_registers(32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
            2: load_registers(32'h0000_0000, 32'h0001_0000, 32'h0000_0000, 32'h0000_0000);
            3: load_registers($urandom, $urandom, $urandom, $urandom);
            default: load_registers($urandom, $urandom_range(32'h0100_0000, 0),
                                    $urandom, $urandom);
        endcase
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        int unsigned done_items;
        int unsigned center;
        bit          counted;
        board = new();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Query before any register write: reset values must hold.
        send_item(bhist_pkg::CMD_QUERY, 8'h00, 17'h08000);
        stop_items();
        drain();

        // Negative base with the widest step: bin 0 gives the base,
        // high bins clamp at the positive limit. Step bit 31 is dropped.
        load_registers(32'hC000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);

        // empty histogram, ignored command code
        send_item(bhist_pkg::CMD_QUERY, 8'h00, 17'h08000);
        send_item(CMD_UNUSED, 8'hFF, 17'h1FFFF);
        send_item(bhist_pkg::CMD_SAMPLE, 8'h00, 17'h00000);
        send_item(bhist_pkg::CMD_SAMPLE, 8'hFF, 17'h1FFFF);
        send_item(bhist_pkg::CMD_SAMPLE, 8'h80, 17'h00000);
        send_item(bhist_pkg::CMD_SAMPLE, 8'hFF, 17'h00000);
        // fraction zero, exactly one, above one
        send_item(bhist_pkg::CMD_QUERY, 8'h00, 17'h00000);
        send_item(bhist_pkg::CMD_QUERY, 8'h00, FRAC_ONE);
        send_item(bhist_pkg::CMD_QUERY, 8'hFF, 17'h1FFFF);
        // smallest fraction stops at the top bin; largest walks to bin 0
        send_item(bhist_pkg::CMD_QUERY, 8'h00, 17'h00001);
        send_item(bhist_pkg::CMD_QUERY, 8'h00, 17'h0FFFF);
        send_item(bhist_pkg::CMD_QUERY, 8'h00, 17'h08000);
        send_item(bhist_pkg::CMD_QUERY, 8'h00, 17'h0C000);
        send_item(bhist_pkg::CMD_SAMPLE, 8'h01, 17'h00000);
        send_item(bhist_pkg::CMD_QUERY, 8'h00, 17'h0FFFF);
        // clear, then empty wins over fraction zero
        send_item(bhist_pkg::CMD_CLEAR, 8'hAA, 17'h15555);
        send_item(bhist_pkg::CMD_QUERY, 8'h00, 17'h00064);
        send_item(bhist_pkg::CMD_QUERY, 8'h00, 17'h00000);
        send_item(bhist_pkg::CMD_SAMPLE, 8'h55, 17'h00000);
        send_item(bhist_pkg::CMD_SAMPLE, 8'hAA, 17'h00000);
        send_item(bhist_pkg::CMD_QUERY, 8'h00, FRAC_ONE);
        send_item(bhist_pkg::CMD_QUERY, 8'h55, 17'h0AAAA);
        stop_items();

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            drain();
            apply_phase_registers(phase);
            // long hold-off during the second phase: the core must back up
            if (phase == 1) hold_wanted = 1'b1;
            center     = $urandom_range(240, 0);
            done_items = 0;
            while (done_items < PHASE_ITEMS) begin
                random_item(center, counted);
                if (counted) done_items++;
            end
            stop_items();
        end

        drain();
        if (board.mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial begin : watchdog
        #(WATCHDOG_NS);
        $display("CHECK FAILED");
        $finish;
    end

endmodule
